### design/rmsh_pkg.sv
// Package: payload structs, controller/datapath command and status types, hash constants.
`timescale 1ns / 1ps

package rmsh_pkg;

    localparam int unsigned MAX_KEY_BYTES = 255;
    localparam logic [31:0] HASH_SEED     = 32'h5C3F_C4D3;
    localparam logic [31:0] HASH_MUL      = 32'h87C1_0417;
    localparam int unsigned SHIFT_MIX     = 24;
    localparam int unsigned SHIFT_AV1     = 13;
    localparam int unsigned SHIFT_AV2     = 15;

    typedef struct packed {
        logic [7:0] key_byte;
        logic [7:0] key_length;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] hash_value;
        logic        length_error;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_K1   = 3'd1,
        OP_K2   = 3'd2,
        OP_HK   = 3'd3,
        OP_HT   = 3'd4,
        OP_HA   = 3'd5
    } t_mul_op;

    typedef struct packed {
        logic    take;
        t_mul_op op;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic word_go;
        logic last_in;
        logic tail_nz;
        logic out_free;
    } t_dp_status;

endpackage

### design/rmsh_ctrl.sv
// Controller: sequences byte transfers, word mixing, tail multiply, avalanche and result load.
`timescale 1ns / 1ps

module rmsh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rmsh_pkg::t_dp_status i_st,
    output logic                o_ready,
    output rmsh_pkg::t_dp_cmd   o_cmd
);
    import rmsh_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_K1   = 7'b0000010,
        S_K2   = 7'b0000100,
        S_HK   = 7'b0001000,
        S_FT   = 7'b0010000,
        S_FA   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_comb begin
        n_state        = r_state;
        n_last         = r_last;
        o_cmd.take     = 1'b0;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        o_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
                if (i_valid) begin
                    n_last = i_st.last_in;
                    if (i_st.word_go) begin
                        n_state = S_K1;
                    end else if (i_st.last_in) begin
                        n_state = S_FT;
                    end
                end
            end
            S_K1: begin
                o_cmd.op = OP_K1;
                n_state  = S_K2;
            end
            S_K2: begin
                o_cmd.op = OP_K2;
                n_state  = S_HK;
            end
            S_HK: begin
                o_cmd.op = OP_HK;
                n_state  = r_last ? S_FT : S_IDLE;
            end
            S_FT: begin
                o_cmd.op = i_st.tail_nz ? OP_HT : OP_NONE;
                n_state  = S_FA;
            end
            S_FA: begin
                o_cmd.op = OP_HA;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

`ifndef ASSERT_OFF
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_K1) |=> (r_state == S_K2) ##1 (r_state == S_HK))
        else $error("word mix sequence broken");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> (o_cmd.op == OP_NONE) && !o_cmd.load_out)
        else $error("transfer taken while datapath busy");

    a_fa_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FA) |=> (r_state == S_OUT))
        else $error("avalanche not followed by result load");
`endif

endmodule

### design/rmsh_datapath.sv
// Datapath: key state registers, shared 32x32 multiplier, result register.
`timescale 1ns / 1ps

module rmsh_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rmsh_pkg::t_in_item   i_data,
    input  rmsh_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_out_ready,
    output rmsh_pkg::t_dp_status o_st,
    output logic                 o_valid,
    output rmsh_pkg::t_out_item  o_data
);
    import rmsh_pkg::*;

    logic [31:0] r_hash, n_hash;
    logic [31:0] r_k, n_k;
    logic [23:0] r_gather, n_gather;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_len, n_len;
    logic        r_inside, n_inside;
    logic        r_ovr, n_ovr;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_out, n_out;

    logic        first, skip, in_body;
    logic [7:0]  e_len, e_cnt, e_body;
    logic [31:0] e_hash;
    logic [23:0] e_gather;
    logic        e_ovr;
    logic [1:0]  e_tail, sh;
    logic [31:0] mul_a, prod;
    logic        err;
    logic [31:0] fin_hash;

    assign first    = !r_inside;
    assign e_len    = first ? i_data.key_length : r_len;
    assign e_cnt    = first ? 8'd0 : r_cnt;
    assign e_hash   = first ? (HASH_SEED ^ {24'd0, i_data.key_length}) : r_hash;
    assign e_gather = first ? 24'd0 : r_gather;
    assign e_ovr    = first ? 1'b0 : r_ovr;
    assign e_tail   = e_len[1:0];
    assign e_body   = {e_len[7:2], 2'b00};
    assign skip     = first && (i_data.key_length == 8'd0);
    assign in_body  = e_cnt < e_body;
    assign sh       = 2'(e_tail - 2'd1 - e_cnt[1:0]);

    assign o_st.word_go  = !skip && (e_cnt < e_len) && in_body && (e_cnt[1:0] == 2'd3);
    assign o_st.last_in  = i_data.last_byte;
    assign o_st.tail_nz  = r_len[1:0] != 2'd0;
    assign o_st.out_free = !r_ovalid || i_out_ready;

    always_comb begin
        case (i_cmd.op)
            OP_K1:          mul_a = r_k;
            OP_K2:          mul_a = r_k ^ (r_k >> SHIFT_MIX);
            OP_HK, OP_HT:   mul_a = r_hash;
            OP_HA:          mul_a = r_hash ^ (r_hash >> SHIFT_AV1);
            default:        mul_a = r_hash;
        endcase
    end

    assign prod     = mul_a * HASH_MUL;
    assign err      = r_ovr || (r_cnt != r_len) || (32'(r_len) > 32'(MAX_KEY_BYTES));
    assign fin_hash = r_hash ^ (r_hash >> SHIFT_AV2);

    always_comb begin
        n_hash   = r_hash;
        n_k      = r_k;
        n_gather = r_gather;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_inside = r_inside;
        n_ovr    = r_ovr;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;

        if (i_cmd.take) begin
            n_hash   = e_hash;
            n_gather = e_gather;
            n_cnt    = e_cnt;
            n_len    = e_len;
            n_ovr    = e_ovr;
            n_inside = 1'b1;
            if (!skip) begin
                if (e_cnt >= e_len) begin
                    n_ovr = 1'b1;
                end else begin
                    n_cnt = e_cnt + 8'd1;
                    if (in_body) begin
                        if (e_cnt[1:0] != 2'd3) begin
                            n_gather = e_gather
                                     | (24'(i_data.key_byte) << {e_cnt[1:0], 3'b000});
                        end else begin
                            n_k      = {i_data.key_byte, e_gather};
                            n_gather = 24'd0;
                        end
                    end else begin
                        n_hash = e_hash ^ (32'(i_data.key_byte) << {sh, 3'b000});
                    end
                end
            end
        end

        case (i_cmd.op)
            OP_K1, OP_K2: n_k    = prod;
            OP_HK:        n_hash = prod ^ r_k;
            OP_HT, OP_HA: n_hash = prod;
            default:      ;
        endcase

        if (i_cmd.load_out) begin
            n_out.hash_value   = err ? 32'd0 : fin_hash;
            n_out.length_error = err;
            n_ovalid           = 1'b1;
            n_hash             = 32'd0;
            n_gather           = 24'd0;
            n_cnt              = 8'd0;
            n_len              = 8'd0;
            n_inside           = 1'b0;
            n_ovr              = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= 32'd0;
            r_gather <= 24'd0;
            r_cnt    <= 8'd0;
            r_len    <= 8'd0;
            r_inside <= 1'b0;
            r_ovr    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_hash   <= n_hash;
            r_gather <= n_gather;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_inside <= n_inside;
            r_ovr    <= n_ovr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_ovalid && !r_inside)
        else $error("result load did not close key");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.length_error) |-> (r_out.hash_value == 32'd0))
        else $error("error result carries nonzero hash");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_cnt <= r_len))
        else $error("byte count past key length");

    a_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && o_st.word_go) |=> (r_gather == 24'd0))
        else $error("gather not cleared on full word");
`endif

endmodule

### design/reverse_murmur2_string_hash.sv
// Top level: streaming reverse-order 32-bit string hash, controller plus datapath.
//
// Input channel (i_valid / o_ready, payload i_data): one key byte per transfer,
// last byte of the key first. The first transfer of a key also carries
// key_length; last_byte marks the final transfer (the key's first byte).
// An empty key is one transfer with key_length 0 and last_byte set.
// Output channel (o_valid / i_ready, payload o_data): one result per key,
// hash_value and length_error; hash_value is 0 when length_error is set.
// A byte that completes a four-byte word holds the input for three passes
// through the single 32x32 multiplier; the last byte of a key holds the input
// until its result loads. After the last byte's transfer, o_valid rises once
// word mix (when that byte completes a word), tail multiply (when the key has
// tail bytes), avalanche multiply and result load have run.
// A stalled receiver holds the result register; the next key's bytes are
// still taken, and only the next result load waits for the register.
// Reset (i_rst_n low, synchronous) clears the key state (all but the word register r_k) and the result valid.
`timescale 1ns / 1ps

module reverse_murmur2_string_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rmsh_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rmsh_pkg::t_out_item o_data
);
    import rmsh_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status st;

    rmsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (st),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    rmsh_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .i_out_ready (i_ready),
        .o_st        (st),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule
